// ===== rtl/atbp_pkg.sv =====
// Shared types, constants and a helper function for the terminal byte processor.
package atbp_pkg;

    localparam int unsigned DefCoordBits = 8;
    localparam int unsigned DefParamBits = 16;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_WRITE     = 4'd1;
    localparam logic [3:0] OP_BLANK     = 4'd2;
    localparam logic [3:0] OP_SCROLL_UP = 4'd3;
    localparam logic [3:0] OP_SCROLL_DN = 4'd4;
    localparam logic [3:0] OP_ERASE_SCR = 4'd5;
    localparam logic [3:0] OP_ERASE_LN  = 4'd6;
    localparam logic [3:0] OP_DEL_CHARS = 4'd7;
    localparam logic [3:0] OP_DEL_LINES = 4'd8;
    localparam logic [3:0] OP_INS_CHARS = 4'd9;
    localparam logic [3:0] OP_INS_LINES = 4'd10;

    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_TAB  = 2'd2;
    localparam logic [1:0] CFG_FG   = 2'd3;

    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_DEL = 8'd127;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [3:0] {
        PH_TEXT = 4'b0001,
        PH_ESC  = 4'b0010,
        PH_CSI1 = 4'b0100,
        PH_CSI2 = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        K_PLAIN,
        K_ESC_M,
        K_CSI,
        K_NOP
    } t_kind;

    typedef struct packed {
        logic [7:0] cols;
        logic [7:0] rows;
        logic [5:0] tab;
        logic [2:0] dfg;
    } t_cfg;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] count;
        logic [7:0] glyph;
        logic [7:0] cattr;
        logic [7:0] battr;
        logic [7:0] cur_col;
        logic [7:0] cur_row;
        logic       last;
    } t_result;

    function automatic logic [2:0] sgr_colour(input logic [2:0] idx);
        logic [2:0] m;
        case (idx)
            3'd0: m = 3'd0;
            3'd1: m = 3'd4;
            3'd2: m = 3'd2;
            3'd3: m = 3'd6;
            3'd4: m = 3'd1;
            3'd5: m = 3'd5;
            3'd6: m = 3'd3;
            default: m = 3'd7;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/atbp_if.sv =====
// Valid/ready stream and configuration write interfaces.
interface atbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    modport source(output valid, output char_byte, input ready);
    modport sink(input valid, input char_byte, output ready);
endinterface

interface atbp_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] screen_op;
    logic [7:0] op_row;
    logic [7:0] op_col;
    logic [7:0] op_count;
    logic [7:0] glyph;
    logic [7:0] char_attribute;
    logic [7:0] blank_attribute;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic       last_of_run;
    modport source(output valid, output screen_op, output op_row, output op_col,
                   output op_count, output glyph, output char_attribute,
                   output blank_attribute, output cursor_col, output cursor_row,
                   output last_of_run, input ready);
    modport sink(input valid, input screen_op, input op_row, input op_col,
                 input op_count, input glyph, input char_attribute,
                 input blank_attribute, input cursor_col, input cursor_row,
                 input last_of_run, output ready);
endinterface

interface atbp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/atbp_front.sv =====
// Front end: escape parser, parameter accumulation and byte classification.
module atbp_front #(
    parameter int unsigned PARAM_BITS = atbp_pkg::DefParamBits
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_byte,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    output atbp_pkg::t_kind        o_kind,
    output logic [7:0]             o_byte,
    output logic [PARAM_BITS-1:0]  o_p1,
    output logic [PARAM_BITS-1:0]  o_p2,
    output logic                   o_p1_seen,
    output logic                   o_p2_seen
);
    import atbp_pkg::*;

    localparam logic [PARAM_BITS-1:0] PMax = '1;

    t_phase                r_phase, n_phase;
    logic [PARAM_BITS-1:0] r_p1, n_p1, r_p2, n_p2;
    logic                  r_s1, n_s1, r_s2, n_s2;
    logic                  r_v;
    t_kind                 r_kind, n_kind;
    logic [7:0]            r_byte;
    logic [PARAM_BITS-1:0] r_op1, r_op2;
    logic                  r_os1, r_os2;
    logic                  take, emit, digit;
    logic [PARAM_BITS+4:0] acc;
    logic [PARAM_BITS-1:0] acc_in;

    assign o_ready = !r_v || i_ready;
    assign take    = i_valid && o_ready;
    assign digit   = i_byte >= 8'h30 && i_byte <= 8'h39;
    assign acc_in  = (r_phase == PH_CSI2) ? r_p2 : r_p1;
    assign acc     = ({5'd0, acc_in} << 3) + ({5'd0, acc_in} << 1)
                   + {{(PARAM_BITS+1){1'b0}}, i_byte[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_p1 = r_p1;
        n_p2 = r_p2;
        n_s1 = r_s1;
        n_s2 = r_s2;
        n_kind = K_NOP;
        emit = 1'b1;
        unique case (r_phase)
            PH_TEXT: begin
                if (i_byte == CH_ESC) begin
                    n_phase = PH_ESC;
                    n_p1 = '0;
                    n_p2 = '0;
                    n_s1 = 1'b0;
                    n_s2 = 1'b0;
                end else begin
                    n_kind = K_PLAIN;
                end
            end
            PH_ESC: begin
                if (i_byte == 8'h5b) begin
                    n_phase = PH_CSI1;
                end else begin
                    n_phase = PH_TEXT;
                    if (i_byte == 8'h4d) begin
                        n_kind = K_ESC_M;
                    end
                end
            end
            PH_CSI1: begin
                if (digit) begin
                    n_p1 = (acc > {5'd0, PMax}) ? PMax : acc[PARAM_BITS-1:0];
                    n_s1 = 1'b1;
                end else if (i_byte == 8'h3b) begin
                    n_phase = PH_CSI2;
                end else begin
                    n_phase = PH_TEXT;
                    n_kind = K_CSI;
                end
            end
            PH_CSI2: begin
                if (digit) begin
                    n_p2 = (acc > {5'd0, PMax}) ? PMax : acc[PARAM_BITS-1:0];
                    n_s2 = 1'b1;
                end else begin
                    n_phase = PH_TEXT;
                    n_kind = K_CSI;
                end
            end
            default: begin
                n_phase = PH_TEXT;
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_p1 <= '0;
            r_p2 <= '0;
            r_s1 <= 1'b0;
            r_s2 <= 1'b0;
            r_v <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_p1 <= n_p1;
                r_p2 <= n_p2;
                r_s1 <= n_s1;
                r_s2 <= n_s2;
                r_v <= emit;
            end else if (i_ready) begin
                r_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= n_kind;
            r_byte <= i_byte;
            r_op1 <= r_p1;
            r_op2 <= r_p2;
            r_os1 <= r_s1;
            r_os2 <= r_s2;
        end
    end

    assign o_valid   = r_v;
    assign o_kind    = r_kind;
    assign o_byte    = r_byte;
    assign o_p1      = r_op1;
    assign o_p2      = r_op2;
    assign o_p1_seen = r_os1;
    assign o_p2_seen = r_os2;

`ifndef SYNTHESIS
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase)) else $error("parser phase not one-hot");
    a_esc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_phase == PH_TEXT && i_byte == CH_ESC |=> !r_s1 && !r_s2)
        else $error("parameters not cleared on escape");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && !i_ready |=> r_v && $stable(r_byte))
        else $error("classified byte lost under stall");
`endif
endmodule

// ===== rtl/atbp_back.sv =====
// Back end: cursor, attribute state and screen command generation.
module atbp_back #(
    parameter int unsigned PARAM_BITS = atbp_pkg::DefParamBits
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  atbp_pkg::t_kind        i_kind,
    input  logic [7:0]             i_byte,
    input  logic [PARAM_BITS-1:0]  i_p1,
    input  logic [PARAM_BITS-1:0]  i_p2,
    input  logic                   i_p1_seen,
    input  logic                   i_p2_seen,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [7:0]             i_cfg_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output atbp_pkg::t_result      o_res
);
    import atbp_pkg::*;

    t_cfg       r_cfg;
    logic [7:0] r_x, r_y, n_x, n_y;
    logic       r_wrap, n_wrap;
    logic [2:0] r_fg, r_bg, n_fg, n_bg;
    logic       r_bold, r_blink, r_rev, n_bold, n_blink, n_rev;
    t_result    r_q0, r_q1;
    logic       r_v0, r_v1;
    logic [3:0] c0_op, c1_op;
    logic [7:0] c0_row, c0_col, c0_cnt, c0_gl, c1_row, c1_col;
    logic       has1, take;
    logic [7:0] cols, rows, cm1, rm1, ts;
    logic [7:0] k, nx8, tabq;
    logic [8:0] sum, tnx;
    logic [PARAM_BITS-1:0] cnt1;
    logic [7:0] cx, cy;
    logic [2:0] f, b;
    logic [7:0] cnt8, hr, hc;
    logic       tab_req;
    logic [7:0] tab_base, dv_try;
    logic       r_dv_run, r_dv_done;
    logic [2:0] r_dv_cnt;
    logic [7:0] r_dv_num, r_dv_rem;

    assign cols = (r_cfg.cols == 8'd0) ? 8'd1 : r_cfg.cols;
    assign rows = (r_cfg.rows == 8'd0) ? 8'd1 : r_cfg.rows;
    assign cm1  = cols - 8'd1;
    assign rm1  = rows - 8'd1;
    assign ts   = (r_cfg.tab == 6'd0) ? 8'd1 : {2'd0, r_cfg.tab};
    assign cnt1 = (!i_p1_seen || i_p1 == '0) ? {{(PARAM_BITS-1){1'b0}}, 1'b1} : i_p1;
    assign cnt8 = (cnt1 > PARAM_BITS'(255)) ? 8'd255 : cnt1[7:0];

    assign tab_req  = i_valid && i_kind == K_PLAIN && i_byte == CH_TAB;
    assign tab_base = r_wrap ? 8'd0 : r_x;
    assign dv_try   = {r_dv_rem[6:0], r_dv_num[7]};
    assign tabq     = tab_base - r_dv_rem;
    assign tnx      = {1'b0, tabq} + {1'b0, ts};

    assign o_ready = !(r_v0 && r_v1) && (!(r_v0 || r_v1) || i_ready) && !i_cfg_we
                     && (!tab_req || r_dv_done);
    assign take    = i_valid && o_ready;

    function automatic logic [7:0] clip(input logic [PARAM_BITS-1:0] v,
                                        input logic [7:0] lim);
        logic [7:0] r;
        r = (v > PARAM_BITS'(lim)) ? lim : v[7:0];
        return r;
    endfunction

    function automatic void sgr(input logic [PARAM_BITS-1:0] n, input logic [2:0] dfg,
                                inout logic rv, inout logic bd, inout logic bl,
                                inout logic [2:0] fg, inout logic [2:0] bg);
        if (n == '0) begin
            rv = 1'b0; bd = 1'b0; bl = 1'b0; bg = 3'd0; fg = dfg;
        end else if (n == PARAM_BITS'(1)) begin
            bd = 1'b1;
        end else if (n == PARAM_BITS'(5)) begin
            bl = 1'b1;
        end else if (n == PARAM_BITS'(7)) begin
            rv = 1'b1;
        end else if (n >= PARAM_BITS'(30) && n < PARAM_BITS'(38)) begin
            fg = sgr_colour(n[2:0] - 3'd6);
        end else if (n == PARAM_BITS'(39)) begin
            fg = dfg;
        end else if (n >= PARAM_BITS'(40) && n < PARAM_BITS'(48)) begin
            bg = sgr_colour(n[2:0]);
        end else if (n == PARAM_BITS'(49)) begin
            bg = 3'd0;
        end
    endfunction

    always_comb begin
        n_x = r_x; n_y = r_y; n_wrap = r_wrap;
        n_fg = r_fg; n_bg = r_bg; n_bold = r_bold; n_blink = r_blink; n_rev = r_rev;
        c0_op = OP_NONE; c0_row = '0; c0_col = '0; c0_cnt = '0; c0_gl = '0;
        c1_op = OP_NONE; c1_row = '0; c1_col = '0;
        has1 = 1'b0;
        k = '0; sum = '0; nx8 = '0; hr = '0; hc = '0;
        cx = r_x; cy = r_y;
        case (i_kind)
            K_PLAIN: begin
                if (i_byte == CH_LF) begin
                    cy = r_y + 8'd1; cx = '0; n_wrap = 1'b0;
                end
                if (r_wrap && i_byte != CH_LF) begin
                    cx = '0; cy = r_y + 8'd1; n_wrap = 1'b0;
                end
                if (cy > rm1 || (cy == 8'd0 && r_y == 8'hff)) begin
                    c0_op = OP_SCROLL_UP;
                    cy = rm1;
                end
                if (i_byte > 8'h1f && i_byte < 8'h7f) begin
                    if (c0_op == OP_NONE) begin
                        c0_op = OP_WRITE; c0_row = cy; c0_col = cx; c0_gl = i_byte;
                    end else begin
                        has1 = 1'b1; c1_op = OP_WRITE; c1_row = cy; c1_col = cx;
                    end
                    if (cx < cm1) cx = cx + 8'd1;
                    else n_wrap = 1'b1;
                end
                if (i_byte == CH_CR) cx = '0;
                if (i_byte == CH_DEL && cx != 8'd0) begin
                    cx = cx - 8'd1;
                    if (c0_op == OP_NONE) begin
                        c0_op = OP_BLANK; c0_row = cy; c0_col = cx;
                    end else begin
                        has1 = 1'b1; c1_op = OP_BLANK; c1_row = cy; c1_col = cx;
                    end
                end
                if (i_byte == CH_BS && cx != 8'd0) cx = cx - 8'd1;
                if (i_byte == CH_TAB) begin
                    cx = (tnx >= {1'b0, cols}) ? cm1 : tnx[7:0];
                end
            end
            K_ESC_M: begin
                if (r_y == 8'd0) begin
                    n_wrap = 1'b0; c0_op = OP_SCROLL_DN;
                end else begin
                    cy = r_y - 8'd1;
                end
            end
            K_CSI: begin
                unique case (i_byte)
                    8'h41: begin
                        k = clip(cnt1, r_y); cy = r_y - k;
                    end
                    8'h42: begin
                        k = clip(cnt1, rm1); sum = {1'b0, r_y} + {1'b0, k};
                        cy = (sum > {1'b0, rm1}) ? rm1 : sum[7:0];
                    end
                    8'h43: begin
                        k = clip(cnt1, cm1); sum = {1'b0, r_x} + {1'b0, k};
                        cx = (sum > {1'b0, cm1}) ? cm1 : sum[7:0];
                        n_wrap = 1'b0;
                    end
                    8'h44: begin
                        k = clip(cnt1, r_x); cx = r_x - k; n_wrap = 1'b0;
                    end
                    8'h48: begin
                        hr = (i_p1_seen && i_p1 == '0) ? 8'd0 :
                             clip(i_p1_seen ? i_p1 - PARAM_BITS'(1) : '0, rm1);
                        hc = (i_p2_seen && i_p2 == '0) ? 8'd0 :
                             clip(i_p2_seen ? i_p2 - PARAM_BITS'(1) : '0, cm1);
                        cx = hc; cy = hr; n_wrap = 1'b0;
                    end
                    8'h4a, 8'h4b: begin
                        if (!i_p1_seen || i_p1 <= PARAM_BITS'(2)) begin
                            c0_op = (i_byte == 8'h4a) ? OP_ERASE_SCR : OP_ERASE_LN;
                            c0_row = r_y; c0_col = r_x;
                            c0_cnt = i_p1_seen ? {6'd0, i_p1[1:0]} : 8'd0;
                        end
                        n_wrap = 1'b0;
                    end
                    8'h6d: begin
                        if (i_p1_seen) sgr(i_p1, r_cfg.dfg, n_rev, n_bold, n_blink, n_fg, n_bg);
                        if (i_p2_seen) sgr(i_p2, r_cfg.dfg, n_rev, n_bold, n_blink, n_fg, n_bg);
                        n_wrap = 1'b0;
                    end
                    8'h50, 8'h40: begin
                        nx8 = cols - r_x;
                        c0_op = (i_byte == 8'h50) ? OP_DEL_CHARS : OP_INS_CHARS;
                        c0_row = r_y; c0_col = r_x;
                        c0_cnt = (cnt8 > nx8) ? nx8 : cnt8;
                        n_wrap = 1'b0;
                    end
                    8'h4d, 8'h4c: begin
                        nx8 = rows - r_y;
                        c0_op = (i_byte == 8'h4d) ? OP_DEL_LINES : OP_INS_LINES;
                        c0_row = r_y; c0_col = r_x;
                        c0_cnt = (cnt8 > nx8) ? nx8 : cnt8;
                        n_wrap = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        n_x = (cx > cm1) ? cm1 : cx;
        n_y = (cy > rm1) ? rm1 : cy;
    end

    always_comb begin
        f = n_rev ? n_bg : n_fg;
        b = n_rev ? n_fg : n_bg;
    end

    // find the column modulo the tab spacing, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_run <= 1'b0;
            r_dv_done <= 1'b0;
            r_dv_cnt <= '0;
            r_dv_num <= '0;
            r_dv_rem <= '0;
        end else if (take) begin
            r_dv_done <= 1'b0;
        end else if (r_dv_run) begin
            r_dv_rem <= (dv_try >= ts) ? dv_try - ts : dv_try;
            r_dv_num <= {r_dv_num[6:0], 1'b0};
            r_dv_cnt <= r_dv_cnt + 3'd1;
            if (r_dv_cnt == 3'd7) begin
                r_dv_run <= 1'b0;
                r_dv_done <= 1'b1;
            end
        end else if (tab_req && !r_dv_done) begin
            r_dv_run <= 1'b1;
            r_dv_cnt <= '0;
            r_dv_num <= tab_base;
            r_dv_rem <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{cols: 8'd80, rows: 8'd25, tab: 6'd8, dfg: 3'd7};
            r_x <= '0; r_y <= '0; r_wrap <= 1'b0;
            r_fg <= 3'd7; r_bg <= 3'd0;
            r_bold <= 1'b0; r_blink <= 1'b0; r_rev <= 1'b0;
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COLS: begin
                        r_cfg.cols <= i_cfg_data;
                        if (r_x > ((i_cfg_data == 8'd0) ? 8'd0 : i_cfg_data - 8'd1))
                            r_x <= (i_cfg_data == 8'd0) ? 8'd0 : i_cfg_data - 8'd1;
                    end
                    CFG_ROWS: begin
                        r_cfg.rows <= i_cfg_data;
                        if (r_y > ((i_cfg_data == 8'd0) ? 8'd0 : i_cfg_data - 8'd1))
                            r_y <= (i_cfg_data == 8'd0) ? 8'd0 : i_cfg_data - 8'd1;
                    end
                    CFG_TAB: r_cfg.tab <= i_cfg_data[5:0];
                    CFG_FG:  r_cfg.dfg <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end else if (take) begin
                r_x <= n_x; r_y <= n_y; r_wrap <= n_wrap;
                r_fg <= n_fg; r_bg <= n_bg;
                r_bold <= n_bold; r_blink <= n_blink; r_rev <= n_rev;
            end
            if (take) begin
                r_v0 <= 1'b1;
                r_v1 <= has1;
            end else if (i_ready) begin
                if (r_v0) r_v0 <= 1'b0;
                else r_v1 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q0 <= '{op: c0_op, row: c0_row, col: c0_col, count: c0_cnt, glyph: c0_gl,
                      cattr: {n_blink, b, n_bold, f},
                      battr: {1'b0, n_bg, 1'b0, n_fg},
                      cur_col: n_x, cur_row: n_y, last: !has1};
            r_q1 <= '{op: c1_op, row: c1_row, col: c1_col, count: 8'd0,
                      glyph: (c1_op == OP_WRITE) ? i_byte : 8'd0,
                      cattr: {n_blink, b, n_bold, f},
                      battr: {1'b0, n_bg, 1'b0, n_fg},
                      cur_col: n_x, cur_row: n_y, last: 1'b1};
        end
    end

    assign o_valid = r_v0 || r_v1;
    assign o_res   = r_v0 ? r_q0 : r_q1;

`ifndef SYNTHESIS
    a_cursor_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x <= cm1 && r_y <= rm1) else $error("cursor outside window");
    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !r_v0 |-> o_res.last) else $error("second command not last");
    a_first_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 |-> (r_q0.last == !r_v1)) else $error("last flag mismatch");
`endif
endmodule

// ===== rtl/ansi_terminal_byte_processor.sv =====
// Top level of the ANSI terminal byte processor.
// Each byte yields one or two screen commands. The front parser takes a byte into a
// one-entry queue whenever that entry is empty or transfers in the same cycle. The back
// end takes a byte when its two result registers are empty or the last waiting command
// transfers in that cycle, so bytes follow back to back. A tab holds the back end while
// the column modulo the tab spacing is found one bit a cycle. A byte passes the front's
// queue entry and then the back end's first result register before its first command
// appears. Configuration writes hold off the back end for their cycle and update the
// window size, tab spacing and default foreground; write them only with no byte in
// flight.
module ansi_terminal_byte_processor #(
    parameter int unsigned PARAM_BITS = atbp_pkg::DefParamBits
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atbp_byte_if.sink  in_if,
    atbp_cfg_if.sink   cfg_if,
    atbp_cmd_if.source out_if
);
    import atbp_pkg::*;

    logic                  f_valid, b_ready;
    t_kind                 f_kind;
    logic [7:0]            f_byte;
    logic [PARAM_BITS-1:0] f_p1, f_p2;
    logic                  f_s1, f_s2;
    t_result               res;

    assign cfg_if.ready = 1'b1;

    atbp_front #(.PARAM_BITS(PARAM_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_if.valid), .i_byte(in_if.char_byte), .o_ready(in_if.ready),
        .o_valid(f_valid), .i_ready(b_ready), .o_kind(f_kind), .o_byte(f_byte),
        .o_p1(f_p1), .o_p2(f_p2), .o_p1_seen(f_s1), .o_p2_seen(f_s2)
    );

    atbp_back #(.PARAM_BITS(PARAM_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(b_ready), .i_kind(f_kind), .i_byte(f_byte),
        .i_p1(f_p1), .i_p2(f_p2), .i_p1_seen(f_s1), .i_p2_seen(f_s2),
        .i_cfg_we(cfg_if.valid), .i_cfg_idx(cfg_if.index), .i_cfg_data(cfg_if.data),
        .o_valid(out_if.valid), .i_ready(out_if.ready), .o_res(res)
    );

    assign out_if.screen_op       = res.op;
    assign out_if.op_row          = res.row;
    assign out_if.op_col          = res.col;
    assign out_if.op_count        = res.count;
    assign out_if.glyph           = res.glyph;
    assign out_if.char_attribute  = res.cattr;
    assign out_if.blank_attribute = res.battr;
    assign out_if.cursor_col      = res.cur_col;
    assign out_if.cursor_row      = res.cur_row;
    assign out_if.last_of_run     = res.last;
endmodule
